[src/ttlb_pkg.sv]
// Shared types, sizes and codes of the text terminal line buffer.
// No dependencies; every other file imports this package.
`default_nettype none

package ttlb_pkg;

	// Ring and view geometry
	localparam int RING_LINES = 96;
	localparam int LINE_COLS  = 31;
	localparam int VIEW_ROWS  = 8;

	// Derived widths
	localparam int SLOT_W = $clog2(RING_LINES);
	localparam int COL_W  = $clog2(LINE_COLS + 1);
	localparam int ADDR_W = $clog2(RING_LINES * LINE_COLS);
	localparam int DIST_W = 17;

	// Line counter saturation point
	localparam logic [15:0] LC_MAX = 16'hFFFF;

	// Function codes
	localparam logic [1:0] FN_PUT  = 2'd0;
	localparam logic [1:0] FN_UP   = 2'd1;
	localparam logic [1:0] FN_DOWN = 2'd2;
	localparam logic [1:0] FN_READ = 2'd3;

	// Character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
		logic [2:0] view_row;
		logic [4:0] view_col;
	} req_t;

	typedef struct packed {
		logic [7:0]  cell_char;
		logic        cell_present;
		logic [4:0]  cursor_column;
		logic [15:0] lines_total;
		logic [15:0] scroll_offset;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic row_map;
		logic len_rd;
		logic chr_rd;
		logic done;
	} cmd_t;

endpackage

`default_nettype wire

[src/text_terminal_line_buffer.sv]
// Character terminal with a scrollable ring of lines: top level.
// Depends on ttlb_pkg, ttlb_ctrl and ttlb_datapath.
//
// A request is taken when start is high and busy is low; one request is
// worked on at a time. A put or scroll request has its result shown in the
// cycle after acceptance; a read-cell request first passes through states
// that map the view row to a ring slot, read the line length memory and
// read the character memory, and then presents the result. Both memory
// reads are registered. Busy drops after the result cycle, so the next
// request can be taken only once the result has been shown. Each result is
// shown on rsp for exactly one cycle with done high; the receiver cannot
// stall it.
// Line lengths come out of reset empty through per-line valid bits, so
// no clearing pass is needed after reset.
`default_nettype none

module text_terminal_line_buffer import ttlb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	cmd_t cmd;

	ttlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.busy   (busy),
		.cmd    (cmd)
	);

	ttlb_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	assign done = cmd.done;

endmodule

`default_nettype wire

[src/ttlb_ctrl.sv]
// Controller of the terminal line buffer: sequences one request at a time.
// Depends on ttlb_pkg.
`default_nettype none

module ttlb_ctrl import ttlb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] func,
	output logic            busy,
	output cmd_t            cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROW  = 3'd1;
	localparam logic [2:0] S_LEN  = 3'd2;
	localparam logic [2:0] S_CHR  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state: reads walk through row mapping and both memories
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (func == FN_READ) ? S_ROW : S_DONE;
				end
			end
			S_ROW:  state_d = S_LEN;
			S_LEN:  state_d = S_CHR;
			S_CHR:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode commands
	assign busy        = (state_q != S_IDLE);
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.row_map = (state_q == S_ROW);
	assign cmd.len_rd  = (state_q == S_LEN);
	assign cmd.chr_rd  = (state_q == S_CHR);
	assign cmd.done    = (state_q == S_DONE);

endmodule

`default_nettype wire

[src/ttlb_datapath.sv]
// Datapath of the terminal line buffer: counters, line length store,
// character store and read-cell mapping. Depends on ttlb_pkg.
`default_nettype none

module ttlb_datapath import ttlb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire req_t req,
	output rsp_t      rsp
);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_LINES - 1);
	localparam logic [15:0]       RING_LC   = 16'(RING_LINES);

	// Architectural state
	logic [15:0]       lc_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COL_W-1:0]  cursor_q;
	logic [15:0]       sb_q;

	// Latched request
	logic [1:0] func_q;
	logic [2:0] row_q;
	logic [4:0] col_q;

	// Read pipeline registers
	logic [SLOT_W-1:0] rd_slot_q;
	logic              present_q;
	logic [COL_W-1:0]  len_rd_q;
	logic              len_ok_q;
	logic              hit_q;
	logic [7:0]        chr_q;

	// Stores
	logic [COL_W-1:0]      len_mem [RING_LINES];
	logic [RING_LINES-1:0] len_vld_q;
	logic [7:0]            char_mem [RING_LINES * LINE_COLS];

	// Next-state and write signals
	logic [15:0]       lc_d;
	logic [SLOT_W-1:0] slot_d;
	logic [COL_W-1:0]  cursor_d;
	logic [15:0]       sb_d;
	logic              len_we;
	logic [SLOT_W-1:0] len_waddr;
	logic [COL_W-1:0]  len_wdata;
	logic              chr_we;
	logic [ADDR_W-1:0] chr_waddr;

	// New-line values
	logic [15:0]       nl_lc;
	logic [SLOT_W-1:0] nl_slot;
	logic              nl_sat;

	// Scroll-up clamp
	logic [DIST_W-1:0] up_val;
	logic [DIST_W-1:0] lim_a;
	logic [DIST_W-1:0] lim;

	// Read mapping
	logic [DIST_W-1:0] row_back;
	logic [SLOT_W-1:0] dist_s;
	logic              row_ok;
	logic [SLOT_W-1:0] map_slot;
	logic [ADDR_W-1:0] chr_raddr;

	logic [SLOT_W-1:0] wr_slot;
	logic [COL_W-1:0]  wr_col;

	assign nl_sat  = (lc_q == LC_MAX);
	assign nl_lc   = nl_sat ? lc_q : lc_q + 16'd1;
	assign nl_slot = nl_sat ? slot_q : ((slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1);

	assign up_val = DIST_W'(sb_q) + DIST_W'(1);
	assign lim_a  = DIST_W'(lc_q) + DIST_W'(1) - DIST_W'(VIEW_ROWS);
	assign lim    = (lim_a < DIST_W'(RING_LINES - VIEW_ROWS)) ? lim_a
	                : DIST_W'(RING_LINES - VIEW_ROWS);

	// Execute put and scroll requests at acceptance
	always_comb begin
		lc_d      = lc_q;
		slot_d    = slot_q;
		cursor_d  = cursor_q;
		sb_d      = sb_q;
		len_we    = 1'b0;
		len_waddr = slot_q;
		len_wdata = '0;
		chr_we    = 1'b0;
		wr_slot   = slot_q;
		wr_col    = cursor_q;
		if (cmd.load) begin
			unique case (req.func)
				FN_PUT: begin
					if (req.char_code == CH_LF) begin
						lc_d      = nl_lc;
						slot_d    = nl_slot;
						cursor_d  = '0;
						len_we    = 1'b1;
						len_waddr = nl_slot;
						if (nl_lc >= RING_LC) begin
							sb_d = '0;
						end
					end else if (req.char_code == CH_CR) begin
						cursor_d = '0;
					end else if (req.char_code == CH_BS) begin
						if (cursor_q != '0) begin
							cursor_d  = cursor_q - 1'b1;
							len_we    = 1'b1;
							len_wdata = cursor_q - 1'b1;
						end
					end else if (req.char_code >= CH_SPACE || req.char_code == CH_TAB) begin
						// wrap to a new line when the current one is full
						if (32'(cursor_q) >= LINE_COLS) begin
							lc_d    = nl_lc;
							slot_d  = nl_slot;
							wr_slot = nl_slot;
							wr_col  = '0;
							if (nl_lc >= RING_LC) begin
								sb_d = '0;
							end
						end
						chr_we    = 1'b1;
						len_we    = 1'b1;
						len_waddr = wr_slot;
						len_wdata = wr_col + 1'b1;
						cursor_d  = wr_col + 1'b1;
					end
				end
				FN_UP: begin
					if (32'(lc_q) >= VIEW_ROWS) begin
						sb_d = 16'((up_val > lim) ? lim : up_val);
					end
				end
				FN_DOWN: begin
					if (sb_q != '0) begin
						sb_d = sb_q - 16'd1;
					end
				end
				FN_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign chr_waddr = ADDR_W'(wr_slot) * ADDR_W'(LINE_COLS) + ADDR_W'(wr_col);

	// Hold architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q      <= '0;
			slot_q    <= '0;
			cursor_q  <= '0;
			sb_q      <= '0;
			len_vld_q <= '0;
		end else begin
			lc_q     <= lc_d;
			slot_q   <= slot_d;
			cursor_q <= cursor_d;
			sb_q     <= sb_d;
			if (len_we) begin
				len_vld_q[len_waddr] <= 1'b1;
			end
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			row_q  <= req.view_row;
			col_q  <= req.view_col;
		end
	end

	// Map the view row to a ring slot, counting back from the current line
	assign row_back = DIST_W'(sb_q) + DIST_W'(VIEW_ROWS - 1) - DIST_W'(row_q);
	assign dist_s   = SLOT_W'(row_back);
	assign row_ok   = (32'(row_q) < VIEW_ROWS);
	assign map_slot = (slot_q >= dist_s) ? slot_q - dist_s
	                  : SLOT_W'((SLOT_W + 1)'(slot_q) + (SLOT_W + 1)'(RING_LINES)
	                  - (SLOT_W + 1)'(dist_s));

	always_ff @(posedge clk) begin
		if (cmd.row_map) begin
			rd_slot_q <= map_slot;
			present_q <= row_ok && (row_back <= DIST_W'(lc_q))
			             && (row_back < DIST_W'(RING_LINES));
		end
	end

	// Line length store
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (cmd.len_rd) begin
			len_rd_q <= len_mem[rd_slot_q];
			len_ok_q <= len_vld_q[rd_slot_q];
		end
	end

	assign chr_raddr = ADDR_W'(rd_slot_q) * ADDR_W'(LINE_COLS) + ADDR_W'(col_q);

	// Character store
	always_ff @(posedge clk) begin
		if (chr_we) begin
			char_mem[chr_waddr] <= req.char_code;
		end
		if (cmd.chr_rd) begin
			chr_q <= char_mem[chr_raddr];
			hit_q <= present_q && len_ok_q && (32'(col_q) < 32'(len_rd_q))
			         && (32'(col_q) < LINE_COLS);
		end
	end

	// Drive the result
	always_comb begin
		rsp.cell_char     = ((func_q == FN_READ) && hit_q) ? chr_q : 8'd0;
		rsp.cell_present  = (func_q == FN_READ) && present_q;
		rsp.cursor_column = 5'(cursor_q);
		rsp.lines_total   = lc_q;
		rsp.scroll_offset = sb_q;
	end

endmodule

`default_nettype wire
